// ===== rtl/aopp_pkg.sv =====
// Shared types, character codes and helpers for the offset pair line parser.
package aopp_pkg;

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    typedef enum logic [1:0] {
        PH_SKIP   = 2'd0,
        PH_SIGN   = 2'd1,
        PH_DIGITS = 2'd2,
        PH_DONE   = 2'd3
    } num_phase_t;

    typedef struct packed {
        logic feed;
        logic restart;
    } num_ctrl_t;

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_VT) || (c == CH_FF);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

endpackage

// ===== rtl/aopp_num.sv =====
// Decimal value accumulator: blank skip, sign, saturating digit accumulation.
module aopp_num #(
    parameter int VALUE_BITS = 16
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  aopp_pkg::num_ctrl_t     ctrl,
    input  logic [7:0]              char_in,
    output logic [VALUE_BITS-1:0]   value
);
    import aopp_pkg::*;

    localparam int ACC_W = VALUE_BITS + 4;
    localparam logic [VALUE_BITS-1:0] LIMIT = VALUE_BITS'(1) << (VALUE_BITS - 1);
    localparam logic [ACC_W-1:0] CAP = ACC_W'(LIMIT) + ACC_W'(1);

    num_phase_t              phase_reg, phase_next;
    logic                    neg_reg, neg_next;
    logic [VALUE_BITS-1:0]   mag_reg, mag_next;

    logic [ACC_W-1:0]        mag_wide;
    logic [ACC_W-1:0]        acc_sum;
    logic [VALUE_BITS-1:0]   acc_sat;
    logic [VALUE_BITS-1:0]   sat_mag;
    logic                    digit;
    logic                    sign_char;

    assign digit     = is_digit(char_in);
    assign sign_char = (char_in == CH_PLUS) || (char_in == CH_MINUS);

    // magnitude * 10 + digit as shift-add
    assign mag_wide = ACC_W'(mag_reg);
    assign acc_sum  = (mag_wide << 3) + (mag_wide << 1) + ACC_W'(char_in[3:0]);
    assign acc_sat  = (acc_sum > CAP) ? CAP[VALUE_BITS-1:0] : acc_sum[VALUE_BITS-1:0];

    // next state
    always_comb begin
        phase_next = phase_reg;
        if (ctrl.restart) begin
            phase_next = PH_SKIP;
        end else if (ctrl.feed) begin
            unique case (phase_reg)
                PH_SKIP: begin
                    if (is_blank(char_in)) begin
                        phase_next = PH_SKIP;
                    end else if (sign_char) begin
                        phase_next = PH_SIGN;
                    end else if (digit) begin
                        phase_next = PH_DIGITS;
                    end else begin
                        phase_next = PH_DONE;
                    end
                end
                PH_SIGN, PH_DIGITS: begin
                    phase_next = digit ? PH_DIGITS : PH_DONE;
                end
                PH_DONE: begin
                    phase_next = PH_DONE;
                end
                default: begin
                    phase_next = PH_DONE;
                end
            endcase
        end
    end

    // datapath updates
    always_comb begin
        neg_next = neg_reg;
        mag_next = mag_reg;
        if (ctrl.restart) begin
            neg_next = 1'b0;
            mag_next = '0;
        end else if (ctrl.feed) begin
            unique case (phase_reg)
                PH_SKIP: begin
                    if (!is_blank(char_in) && sign_char) begin
                        neg_next = (char_in == CH_MINUS);
                    end else if (digit) begin
                        mag_next = acc_sat;
                    end
                end
                PH_SIGN, PH_DIGITS: begin
                    if (digit) begin
                        mag_next = acc_sat;
                    end
                end
                PH_DONE: begin
                    mag_next = mag_reg;
                end
                default: begin
                    mag_next = mag_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_SKIP;
            neg_reg   <= 1'b0;
            mag_reg   <= '0;
        end else begin
            phase_reg <= phase_next;
            neg_reg   <= neg_next;
            mag_reg   <= mag_next;
        end
    end

    // saturated two's complement view
    always_comb begin
        if (neg_reg) begin
            sat_mag = (mag_reg > LIMIT) ? LIMIT : mag_reg;
            value   = VALUE_BITS'(0) - sat_mag;
        end else begin
            sat_mag = (mag_reg > (LIMIT - VALUE_BITS'(1))) ? (LIMIT - VALUE_BITS'(1)) : mag_reg;
            value   = sat_mag;
        end
    end

endmodule

// ===== rtl/aopp_obuf.sv =====
// Result register: holds one beat, refills in the cycle it drains.
module aopp_obuf #(
    parameter int DATA_W = 32
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [DATA_W-1:0] in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [DATA_W-1:0] out_data
);
    logic              valid_reg, valid_next;
    logic [DATA_W-1:0] data_reg, data_next;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb begin
        valid_next = valid_reg;
        data_next  = data_reg;
        if (in_valid && in_ready) begin
            valid_next = 1'b1;
            data_next  = in_data;
        end else if (out_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

endmodule

// ===== rtl/ascii_offset_pair_line_parser_unit.sv =====
// A terminator beat's result is registered and appears on m_tvalid in the cycle after it is accepted.
// Throughput: one byte per cycle; s_tready drops only while a result is held and m_tready is low.
// The result register is the only stage; line and value state update at the input handshake.
// Reset: aresetn synchronous active low, clears line state, value state and result valid.
// Top level of the offset pair line parser.
module ascii_offset_pair_line_parser_unit #(
    parameter int MAX_LINE   = 64,
    parameter int VALUE_BITS = 16
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [7:0]                            s_tdata,  // [7:0] rx_byte
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [((2*VALUE_BITS+7)/8)*8-1:0]     m_tdata   // offset_x, offset_y, zero pad
);
    import aopp_pkg::*;

    localparam int CNT_W = $clog2(MAX_LINE + 1);
    localparam int OUT_W = ((2*VALUE_BITS+7)/8)*8;
    localparam int PAD_W = OUT_W - 2*VALUE_BITS;

    logic [CNT_W-1:0]      line_count_reg, line_count_next;
    logic                  too_long_reg, too_long_next;
    logic                  after_comma_reg, after_comma_next;
    logic                  ended_reg, ended_next;
    logic [VALUE_BITS-1:0] first_reg, first_next;

    num_ctrl_t             num_ctrl;
    logic [VALUE_BITS-1:0] cur_value;
    logic                  beat_in;
    logic                  is_term;
    logic                  emit;
    logic [OUT_W-1:0]      result;

    assign beat_in = s_tvalid && s_tready;
    assign is_term = (s_tdata == CH_CR) || (s_tdata == CH_LF);
    assign emit    = beat_in && is_term && !too_long_reg && after_comma_reg;

    generate
        if (PAD_W > 0) begin : g_pad
            assign result = {{PAD_W{1'b0}}, cur_value, first_reg};
        end else begin : g_nopad
            assign result = {cur_value, first_reg};
        end
    endgenerate

    always_comb begin
        line_count_next  = line_count_reg;
        too_long_next    = too_long_reg;
        after_comma_next = after_comma_reg;
        ended_next       = ended_reg;
        first_next       = first_reg;
        num_ctrl         = '0;
        if (beat_in) begin
            if (is_term) begin
                line_count_next  = '0;
                too_long_next    = 1'b0;
                after_comma_next = 1'b0;
                ended_next       = 1'b0;
                first_next       = '0;
                num_ctrl.restart = 1'b1;
            end else begin
                if (line_count_reg >= CNT_W'(MAX_LINE - 1)) begin
                    too_long_next = 1'b1;
                end
                if (line_count_reg < CNT_W'(MAX_LINE)) begin
                    line_count_next = line_count_reg + CNT_W'(1);
                end
                if (!ended_reg) begin
                    if (s_tdata == CH_NUL) begin
                        ended_next = 1'b1;
                    end else if ((s_tdata == CH_COMMA) && !after_comma_reg) begin
                        first_next       = cur_value;
                        after_comma_next = 1'b1;
                        num_ctrl.restart = 1'b1;
                    end else begin
                        num_ctrl.feed = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_count_reg  <= '0;
            too_long_reg    <= 1'b0;
            after_comma_reg <= 1'b0;
            ended_reg       <= 1'b0;
            first_reg       <= '0;
        end else begin
            line_count_reg  <= line_count_next;
            too_long_reg    <= too_long_next;
            after_comma_reg <= after_comma_next;
            ended_reg       <= ended_next;
            first_reg       <= first_next;
        end
    end

    aopp_num #(
        .VALUE_BITS(VALUE_BITS)
    ) u_num (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (num_ctrl),
        .char_in (s_tdata),
        .value   (cur_value)
    );

    aopp_obuf #(
        .DATA_W(OUT_W)
    ) u_obuf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (emit),
        .in_ready  (s_tready),
        .in_data   (result),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata)
    );

    a_emit_on_term: assert property (@(posedge aclk) disable iff (!aresetn)
        emit |-> is_term)
        else $error("result loaded on a non-terminator beat");

    a_term_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (beat_in && is_term) |=> (line_count_reg == '0) && !after_comma_reg && !ended_reg)
        else $error("line state not cleared after terminator");

    a_long_count: assert property (@(posedge aclk) disable iff (!aresetn)
        too_long_reg |-> (line_count_reg == CNT_W'(MAX_LINE)))
        else $error("long line flag without saturated count");

    a_ready_free: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty result register");

    a_emit_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        emit |=> m_tvalid)
        else $error("loaded result not presented");

endmodule
